/* hdl/lrcl_pkg.sv */
// ----------------------------------------------------------------------------
// lrcl_pkg
// Shared types and constants of the color-interpolating line rasterizer.
// ----------------------------------------------------------------------------
package lrcl_pkg;

  // field widths fixed by the request and pixel formats
  localparam int FIELD_COORD_W = 6;
  localparam int COLOR_W       = 32;
  localparam int CHAN_W        = 8;
  localparam int NUM_CHAN      = 4;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from the word address bit
  localparam logic REG_ERROR_RULE = 1'b0;

  // error rule codes
  localparam logic RULE_BRESENHAM = 1'b0;
  localparam logic RULE_MIDPOINT  = 1'b1;

  // line request: two endpoints with packed rgba colors
  typedef struct packed {
    logic [FIELD_COORD_W-1:0] first_x;
    logic [FIELD_COORD_W-1:0] first_y;
    logic [COLOR_W-1:0]       first_color;
    logic [FIELD_COORD_W-1:0] second_x;
    logic [FIELD_COORD_W-1:0] second_y;
    logic [COLOR_W-1:0]       second_color;
  } line_req_t;

  // emitted pixel
  typedef struct packed {
    logic [FIELD_COORD_W-1:0] pixel_x;
    logic [FIELD_COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]       pixel_color;
    logic                     last_pixel;
  } pixel_t;

endpackage

/* hdl/lrcl_div.sv */
// ----------------------------------------------------------------------------
// lrcl_div
// Restoring divider, one quotient bit per cycle, shared by the color channels
// to split each channel delta into whole steps and a remainder per pixel.
// ----------------------------------------------------------------------------
module lrcl_div import lrcl_pkg::*; #(
  parameter int DIVISOR_W = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CHAN_W-1:0]    dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [CHAN_W-1:0]    quot_o,
  output logic [DIVISOR_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(CHAN_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CHAN_W-1:0]    quo_q, quo_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;

  logic [DIVISOR_W:0] trial;
  logic               fits;

  // one trial subtraction per cycle
  assign trial = {rem_q, quo_q[CHAN_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[CHAN_W-2:0], fits};
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : DIVISOR_W'(trial);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CHAN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/lrcl_step.sv */
// ----------------------------------------------------------------------------
// lrcl_step
// One step along the major axis: error term and minor coordinate update, and
// the per-channel quotient and remainder advance that gives the pixel color.
// ----------------------------------------------------------------------------
module lrcl_step import lrcl_pkg::*; #(
  parameter int COORD_W = 6
) (
  input  logic                                 rule_i,
  input  logic                                 step_neg_i,
  input  logic [COORD_W-1:0]                   big_i,
  input  logic [COORD_W-1:0]                   small_i,
  input  logic [COORD_W-1:0]                   ma_i,
  input  logic [COORD_W-1:0]                   mi_i,
  input  logic signed [COORD_W+2:0]            err_i,
  input  logic [NUM_CHAN-1:0][CHAN_W-1:0]      lo_i,
  input  logic [NUM_CHAN-1:0]                  neg_i,
  input  logic [NUM_CHAN-1:0][CHAN_W-1:0]      qd_i,
  input  logic [NUM_CHAN-1:0][COORD_W-1:0]     rd_i,
  input  logic [NUM_CHAN-1:0][CHAN_W-1:0]      q_i,
  input  logic [NUM_CHAN-1:0][COORD_W-1:0]     r_i,
  output logic [COORD_W-1:0]                   ma_o,
  output logic [COORD_W-1:0]                   mi_o,
  output logic signed [COORD_W+2:0]            err_o,
  output logic [NUM_CHAN-1:0][CHAN_W-1:0]      q_o,
  output logic [NUM_CHAN-1:0][COORD_W-1:0]     r_o,
  output logic [COLOR_W-1:0]                   color_o
);

  localparam int EW = COORD_W + 3;

  logic signed [EW-1:0] two_big;
  logic signed [EW-1:0] two_small;
  logic signed [EW-1:0] err_add;
  logic                 move;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;

  assign two_big   = $signed({2'b00, big_i, 1'b0});
  assign two_small = $signed({2'b00, small_i, 1'b0});
  assign err_add   = err_i + two_small;
  assign ma_o      = ma_i + 1'b1;

  // error term and minor axis move
  always_comb begin
    if (rule_i == RULE_MIDPOINT) begin
      move  = (err_i <= 0);
      err_o = move ? (err_i + two_big - two_small) : (err_i - two_small);
    end else begin
      move  = (err_add >= 0);
      err_o = move ? (err_add - two_big) : err_add;
    end
    if (!move) begin
      mi_o = mi_i;
    end else if (step_neg_i) begin
      mi_o = mi_i - 1'b1;
    end else begin
      mi_o = mi_i + 1'b1;
    end
  end

  // color lanes: quotient and remainder of |delta| * i / d kept incrementally
  always_comb begin
    logic [COORD_W:0] rsum;
    logic             carry;
    for (int c = 0; c < NUM_CHAN; c++) begin
      rsum    = {1'b0, r_i[c]} + {1'b0, rd_i[c]};
      carry   = rsum >= {1'b0, big_i};
      r_o[c]  = carry ? COORD_W'(rsum - {1'b0, big_i}) : COORD_W'(rsum);
      q_o[c]  = q_i[c] + qd_i[c] + CHAN_W'(carry);
      chan[c] = neg_i[c] ? (lo_i[c] - q_o[c]) : (lo_i[c] + q_o[c]);
    end
  end

  assign color_o = chan;

endmodule

/* hdl/line_raster_color_lerp_top.sv */
// ----------------------------------------------------------------------------
// line_raster_color_lerp_top
// Color-interpolating line rasterizer for a square tile: emits both endpoints,
// then the interior pixels along the major axis with per-channel color lerp.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   --------  ---------  ----------------------  ------------
//   in        input      in_valid_i / in_stall_o line_req_t
//   out       output     out_valid_o/out_stall_i pixel_t
//   config    input      apb write/read          error_rule
//
// A line is accepted in the idle state, then one shared restoring divider
// splits the four color deltas by the major extent, one channel at a time,
// then one pixel per cycle, unless out_stall_i holds, for the D+1 pixels.
// Equal endpoints are accepted and emit no pixel. The request side stalls for
// the whole line; the last pixel may wait in the output register while the
// next request is accepted. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module line_raster_color_lerp_top import lrcl_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  line_req_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pixel_t                out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = COORD_BITS;
  localparam int EW = CW + 3;

  // sequencer states
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DIV_GO   = 2'd1;
  localparam logic [1:0] ST_DIV_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT     = 2'd3;

  // emit phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_INNER  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [1:0] ch_q, ch_d;
  logic       out_valid_q, out_valid_d;
  logic       rule_q;
  logic       accept;
  logic       load;

  // line registers
  logic [CW-1:0]      x0_q, y0_q, x1_q, y1_q;
  logic [COLOR_W-1:0] c0_q, c1_q;
  logic               xmaj_q, step_neg_q, line_rule_q;
  logic [CW-1:0]      big_q, small_q, ma1_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] lo_q, hi_q;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] qd_q, q_q;
  logic [NUM_CHAN-1:0][CW-1:0]     rd_q, r_q;
  logic [NUM_CHAN-1:0]             neg_q;
  logic [CW-1:0]        ma_q, mi_q;
  logic signed [EW-1:0] err_q;
  pixel_t               out_q, out_d;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ERROR_RULE) ? CFG_DATA_W'(rule_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= RULE_BRESENHAM;
    end else if (cfg_wr && paddr[2] == REG_ERROR_RULE) begin
      rule_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // request setup: extents, major axis, ordering along it
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        ax, ay, bx, by, dx, dy, big, minor_ext;
  logic [CW-1:0]        ma0_r, mi0_r, ma1_r, mi1_r, ma0, mi0, ma1, mi1;
  logic                 xmaj, swap, same;
  logic signed [EW-1:0] err_init;

  always_comb begin
    ax        = in_data_i.first_x[CW-1:0];
    ay        = in_data_i.first_y[CW-1:0];
    bx        = in_data_i.second_x[CW-1:0];
    by        = in_data_i.second_y[CW-1:0];
    dx        = (ax > bx) ? (ax - bx) : (bx - ax);
    dy        = (ay > by) ? (ay - by) : (by - ay);
    xmaj      = dx >= dy;
    big       = xmaj ? dx : dy;
    minor_ext = xmaj ? dy : dx;
    ma0_r     = xmaj ? ax : ay;
    mi0_r     = xmaj ? ay : ax;
    ma1_r     = xmaj ? bx : by;
    mi1_r     = xmaj ? by : bx;
    swap      = ma0_r > ma1_r;
    ma0       = swap ? ma1_r : ma0_r;
    mi0       = swap ? mi1_r : mi0_r;
    ma1       = swap ? ma0_r : ma1_r;
    mi1       = swap ? mi0_r : mi1_r;
    same      = (ax == bx) && (ay == by);
    if (rule_q == RULE_MIDPOINT) begin
      err_init = $signed({3'b000, big}) - $signed({2'b00, minor_ext, 1'b0});
    end else begin
      err_init = -$signed({3'b000, big});
    end
  end

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = state_q != ST_IDLE;

  // ---------------------------------------------------------------------------
  // shared divider: |hi - lo| / d for each channel in turn
  // ---------------------------------------------------------------------------
  logic [CHAN_W:0]   diff;
  logic              diff_neg;
  logic [CHAN_W-1:0] diff_mag;
  logic              div_start, div_done;
  logic [CHAN_W-1:0] div_quot;
  logic [CW-1:0]     div_rem;

  assign diff      = {1'b0, hi_q[ch_q]} - {1'b0, lo_q[ch_q]};
  assign diff_neg  = diff[CHAN_W];
  assign diff_mag  = diff_neg ? (lo_q[ch_q] - hi_q[ch_q]) : diff[CHAN_W-1:0];
  assign div_start = state_q == ST_DIV_GO;

  lrcl_div #(
    .DIVISOR_W (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_mag),
    .divisor_i  (big_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------------------
  // major-axis step
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        ma_n, mi_n;
  logic signed [EW-1:0] err_n;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] q_n;
  logic [NUM_CHAN-1:0][CW-1:0]     r_n;
  logic [COLOR_W-1:0]   color_n;
  logic                 inner_last;

  lrcl_step #(
    .COORD_W (CW)
  ) u_step (
    .rule_i     (line_rule_q),
    .step_neg_i (step_neg_q),
    .big_i      (big_q),
    .small_i    (small_q),
    .ma_i       (ma_q),
    .mi_i       (mi_q),
    .err_i      (err_q),
    .lo_i       (lo_q),
    .neg_i      (neg_q),
    .qd_i       (qd_q),
    .rd_i       (rd_q),
    .q_i        (q_q),
    .r_i        (r_q),
    .ma_o       (ma_n),
    .mi_o       (mi_n),
    .err_o      (err_n),
    .q_o        (q_n),
    .r_o        (r_n),
    .color_o    (color_n)
  );

  assign inner_last = ma_n == (ma1_q - 1'b1);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    ch_d    = ch_q;
    out_d   = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !same) begin
          state_d = ST_DIV_GO;
          ch_d    = '0;
          phase_d = PH_FIRST;
        end
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          ch_d    = ch_q + 1'b1;
          state_d = (ch_q == 2'(NUM_CHAN - 1)) ? ST_EMIT : ST_DIV_GO;
        end
      end
      ST_EMIT: begin
        if (load) begin
          unique case (phase_q)
            PH_FIRST: begin
              out_d.pixel_x     = FIELD_COORD_W'(x0_q);
              out_d.pixel_y     = FIELD_COORD_W'(y0_q);
              out_d.pixel_color = c0_q;
              out_d.last_pixel  = 1'b0;
              phase_d           = PH_SECOND;
            end
            PH_SECOND: begin
              out_d.pixel_x     = FIELD_COORD_W'(x1_q);
              out_d.pixel_y     = FIELD_COORD_W'(y1_q);
              out_d.pixel_color = c1_q;
              out_d.last_pixel  = big_q == CW'(1);
              phase_d           = PH_INNER;
              if (big_q == CW'(1)) begin
                state_d = ST_IDLE;
              end
            end
            default: begin
              out_d.pixel_x     = FIELD_COORD_W'(xmaj_q ? ma_n : mi_n);
              out_d.pixel_y     = FIELD_COORD_W'(xmaj_q ? mi_n : ma_n);
              out_d.pixel_color = color_n;
              out_d.last_pixel  = inner_last;
              if (inner_last) begin
                state_d = ST_IDLE;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // line and walk registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      x0_q        <= ax;
      y0_q        <= ay;
      x1_q        <= bx;
      y1_q        <= by;
      c0_q        <= in_data_i.first_color;
      c1_q        <= in_data_i.second_color;
      xmaj_q      <= xmaj;
      big_q       <= big;
      small_q     <= minor_ext;
      ma1_q       <= ma1;
      step_neg_q  <= mi1 < mi0;
      line_rule_q <= rule_q;
      lo_q        <= swap ? in_data_i.second_color : in_data_i.first_color;
      hi_q        <= swap ? in_data_i.first_color : in_data_i.second_color;
      ma_q        <= ma0;
      mi_q        <= mi0;
      err_q       <= err_init;
      q_q         <= '0;
      r_q         <= '0;
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      qd_q[ch_q]  <= div_quot;
      rd_q[ch_q]  <= div_rem;
      neg_q[ch_q] <= diff_neg;
    end
    if (load && phase_q == PH_INNER) begin
      ma_q  <= ma_n;
      mi_q  <= mi_n;
      err_q <= err_n;
      q_q   <= q_n;
      r_q   <= r_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // divider results only arrive while the sequencer waits for them
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside of the wait state");

  // per-pixel remainders stay below the major extent
  a_rem_below_d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (r_q[0] < big_q) && (r_q[1] < big_q) &&
                             (r_q[2] < big_q) && (r_q[3] < big_q))
    else $error("color remainder reached the major extent");

  // interior walk never reaches the far endpoint
  a_walk_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && phase_q == PH_INNER) |-> ({1'b0, ma_q} + 1'b1 < {1'b0, ma1_q}))
    else $error("interior walk passed the far endpoint");

  // a pixel flagged last ends the line
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_d.last_pixel) |=> state_q == ST_IDLE)
    else $error("line continued after its last pixel");

endmodule
